### rtl/ntfsrl_pkg.sv
// Shared constants and stage payload types of the NTFS run-list decoder.
`default_nettype none

package ntfsrl_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned HALF_W          = WORD_W / 2;
    localparam int unsigned LANES           = WORD_W / 8;
    localparam int unsigned POS_W           = $clog2(LANES);
    localparam int unsigned NIB_W           = 4;
    localparam int unsigned BPC_W           = 22;
    localparam int unsigned PROD_W          = HALF_W + BPC_W;
    localparam int unsigned MAX_FIELD_BYTES = 8;

    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(4096);

    typedef struct packed {
        logic ext_valid;
        logic sparse;
        logic done;
        logic bad;
    } ntfsrl_flags_t;

    // decoded run: cluster numbers before scaling
    typedef struct packed {
        logic [WORD_W-1:0] cluster;
        logic [WORD_W-1:0] len_clusters;
        ntfsrl_flags_t     flags;
    } ntfsrl_run_t;

    // partial products; high halves only need their low 32 bits mod 2^64
    typedef struct packed {
        logic [PROD_W-1:0] off_lo;
        logic [HALF_W-1:0] off_hi;
        logic [PROD_W-1:0] len_lo;
        logic [HALF_W-1:0] len_hi;
        ntfsrl_flags_t     flags;
    } ntfsrl_part_t;

    typedef struct packed {
        logic [WORD_W-1:0] byte_off;
        logic [WORD_W-1:0] byte_len;
        ntfsrl_flags_t     flags;
    } ntfsrl_ext_t;

endpackage

`default_nettype wire

### rtl/ntfsrl_if.sv
// Valid/ready channel interfaces: run-list bytes in, extents out.
`default_nettype none

interface ntfsrl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_byte;
    logic       list_start;
    logic       last_byte;

    modport source (output valid, output run_byte, output list_start, output last_byte,
                    input ready);
    modport sink   (input valid, input run_byte, input list_start, input last_byte,
                    output ready);
endinterface

interface ntfsrl_extent_if;
    import ntfsrl_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] extent_byte_offset;
    logic [WORD_W-1:0] extent_byte_length;
    logic              extent_valid;
    logic              sparse_run;
    logic              list_done;
    logic              bad_header;

    modport source (output valid, output extent_byte_offset, output extent_byte_length,
                    output extent_valid, output sparse_run, output list_done,
                    output bad_header, input ready);
    modport sink   (input valid, input extent_byte_offset, input extent_byte_length,
                    input extent_valid, input sparse_run, input list_done,
                    input bad_header, output ready);
endinterface

`default_nettype wire

### rtl/ntfs_run_list_decoder_core.sv
// Top level of the NTFS run-list decoder: byte parser and scaling pipeline.
//
//  channel      dir  handshake      payload
//  run_bytes    in   valid/ready    run_byte[7:0], list_start, last_byte
//  extents      out  valid/ready    extent_byte_offset/length[63:0], 4 flags
//  cfg          in   cfg_wr_en      cfg_wr_data[21:0] = bytes_per_cluster
//
// One byte is taken per cycle while ready is high. A byte that ends a run,
// ends the list or hits a bad header yields one item, which the accepting
// edge loads into stage 1 and which then moves through stage 2 and stage 3
// (output register): the parse + cluster add sits before stage 1, the 32x22
// partial products before stage 2 and the recombining adds before stage 3.
// Per-stage enables let bubbles collapse; ready drops only when all three
// stages are full and the sink stalls. Reset loads a cluster size of 4096
// and an empty list; no clearing pass is needed.
`default_nettype none

module ntfs_run_list_decoder_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ntfsrl_pkg::BPC_W-1:0]   cfg_wr_data,
    ntfsrl_byte_if.sink                         run_bytes,
    ntfsrl_extent_if.source                     extents
);
    import ntfsrl_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET
    } phase_t;

    // per-run parse state; cleared between runs
    typedef struct packed {
        phase_t            phase;
        logic [NIB_W-1:0]  len_left;
        logic [NIB_W-1:0]  off_left;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] len_acc;
        logic [WORD_W-1:0] delta_acc;
    } run_st_t;

    localparam run_st_t RUN_CLEAR = '{
        phase:     PH_HEADER,
        len_left:  '0,
        off_left:  '0,
        pos:       '0,
        len_acc:   '0,
        delta_acc: '0
    };

    // Drop byte b into lane pos; with fill set, lanes above pos take the sign.
    function automatic logic [WORD_W-1:0] place_byte(
        input logic [WORD_W-1:0] acc,
        input logic [7:0]        b,
        input logic [POS_W-1:0]  pos,
        input logic              fill
    );
        logic [WORD_W-1:0] r;
        r = acc;
        for (int i = 0; i < LANES; i++) begin
            if (POS_W'(i) == pos) begin
                r[8*i +: 8] = b;
            end else if (fill && (POS_W'(i) > pos)) begin
                r[8*i +: 8] = {8{b[7]}};
            end
        end
        return r;
    endfunction

    logic [BPC_W-1:0]  bpc_reg;
    run_st_t           run_reg,  run_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic              fin_reg,  fin_next;

    logic              v1_reg, v2_reg, v3_reg;
    ntfsrl_run_t       s1_reg;
    ntfsrl_part_t      s2_reg;
    ntfsrl_ext_t       s3_reg;

    logic              en1, en2, en3;
    logic              in_fire;
    logic              res_valid;
    ntfsrl_run_t       res;
    ntfsrl_part_t      part;
    ntfsrl_ext_t       ext;

    // ---------------------------------------------------------------
    // Stage 0: header / field parser and cluster accumulator
    // ---------------------------------------------------------------
    always_comb
    begin
        run_st_t           cur;
        logic [WORD_W-1:0] prev_cur;
        logic              fin_cur;
        logic [7:0]        b;
        logic              last;
        logic [NIB_W-1:0]  ln;
        logic [NIB_W-1:0]  on;
        logic              chk_last;
        logic [WORD_W-1:0] placed;

        b        = run_bytes.run_byte;
        last     = run_bytes.last_byte;
        ln       = b[NIB_W-1:0];
        on       = b[7:NIB_W];
        chk_last = 1'b0;

        // list_start wipes the list before the byte is parsed as a header
        cur      = run_bytes.list_start ? RUN_CLEAR : run_reg;
        prev_cur = run_bytes.list_start ? '0 : prev_reg;
        fin_cur  = run_bytes.list_start ? 1'b0 : fin_reg;

        run_next  = cur;
        prev_next = prev_cur;
        fin_next  = fin_cur;
        res_valid = 1'b0;
        res       = '0;
        placed    = '0;

        if (!fin_cur) begin
            unique case (cur.phase)
                PH_HEADER:
                begin
                    if (b == 8'd0) begin
                        fin_next       = 1'b1;
                        res_valid      = 1'b1;
                        res.flags.done = 1'b1;
                    end else if ((ln == '0) || (ln > NIB_W'(MAX_FIELD_BYTES))
                                 || (on > NIB_W'(MAX_FIELD_BYTES))) begin
                        fin_next       = 1'b1;
                        res_valid      = 1'b1;
                        res.flags.bad  = 1'b1;
                        res.flags.done = last;
                    end else begin
                        run_next          = RUN_CLEAR;
                        run_next.phase    = PH_LENGTH;
                        run_next.len_left = ln;
                        run_next.off_left = on;
                        chk_last          = 1'b1;
                    end
                end
                PH_LENGTH:
                begin
                    placed            = place_byte(cur.len_acc, b, cur.pos, 1'b0);
                    run_next.len_acc  = placed;
                    run_next.pos      = cur.pos + 1'b1;
                    run_next.len_left = cur.len_left - 1'b1;
                    if (cur.len_left == NIB_W'(1)) begin
                        run_next.pos = '0;
                        if (cur.off_left == '0) begin
                            // sparse run: cluster stays put
                            run_next           = RUN_CLEAR;
                            fin_next           = last;
                            res_valid          = 1'b1;
                            res.len_clusters   = placed;
                            res.flags.ext_valid = 1'b1;
                            res.flags.sparse   = 1'b1;
                            res.flags.done     = last;
                        end else begin
                            run_next.phase = PH_OFFSET;
                            chk_last       = 1'b1;
                        end
                    end else begin
                        chk_last = 1'b1;
                    end
                end
                PH_OFFSET:
                begin
                    if (cur.off_left == NIB_W'(1)) begin
                        // highest offset byte: its top bit is the sign
                        placed              = place_byte(cur.delta_acc, b, cur.pos, 1'b1);
                        prev_next           = prev_cur + placed;
                        run_next            = RUN_CLEAR;
                        fin_next            = last;
                        res_valid           = 1'b1;
                        res.cluster         = prev_next;
                        res.len_clusters    = cur.len_acc;
                        res.flags.ext_valid = 1'b1;
                        res.flags.done      = last;
                    end else begin
                        placed             = place_byte(cur.delta_acc, b, cur.pos, 1'b0);
                        run_next.delta_acc = placed;
                        run_next.pos       = cur.pos + 1'b1;
                        run_next.off_left  = cur.off_left - 1'b1;
                        chk_last           = 1'b1;
                    end
                end
                default:
                begin
                    run_next = RUN_CLEAR;
                end
            endcase

            // attribute ends mid-run: drop the partial run
            if (chk_last && last) begin
                run_next       = RUN_CLEAR;
                fin_next       = 1'b1;
                res_valid      = 1'b1;
                res            = '0;
                res.flags.done = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 -> 2: 32x22 partial products
    // ---------------------------------------------------------------
    always_comb
    begin
        part.off_lo = PROD_W'(s1_reg.cluster[HALF_W-1:0]) * PROD_W'(bpc_reg);
        part.off_hi = s1_reg.cluster[WORD_W-1:HALF_W] * HALF_W'(bpc_reg);
        part.len_lo = PROD_W'(s1_reg.len_clusters[HALF_W-1:0]) * PROD_W'(bpc_reg);
        part.len_hi = s1_reg.len_clusters[WORD_W-1:HALF_W] * HALF_W'(bpc_reg);
        part.flags  = s1_reg.flags;
    end

    // ---------------------------------------------------------------
    // Stage 2 -> 3: recombine modulo 2^64
    // ---------------------------------------------------------------
    always_comb
    begin
        ext.byte_off = WORD_W'(s2_reg.off_lo) + {s2_reg.off_hi, HALF_W'(0)};
        ext.byte_len = WORD_W'(s2_reg.len_lo) + {s2_reg.len_hi, HALF_W'(0)};
        ext.flags    = s2_reg.flags;
    end

    // stage enables: a stage loads when empty or when it empties this cycle
    assign en3     = !v3_reg || extents.ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign in_fire = run_bytes.valid && run_bytes.ready;

    assign run_bytes.ready = en1;

    assign extents.valid              = v3_reg;
    assign extents.extent_byte_offset = s3_reg.byte_off;
    assign extents.extent_byte_length = s3_reg.byte_len;
    assign extents.extent_valid       = s3_reg.flags.ext_valid;
    assign extents.sparse_run         = s3_reg.flags.sparse;
    assign extents.list_done          = s3_reg.flags.done;
    assign extents.bad_header         = s3_reg.flags.bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bpc_reg  <= BPC_RESET;
            run_reg  <= RUN_CLEAR;
            prev_reg <= '0;
            fin_reg  <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            s3_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                bpc_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                run_reg  <= run_next;
                prev_reg <= prev_next;
                fin_reg  <= fin_next;
            end
            if (en1) begin
                v1_reg <= in_fire && res_valid;
                s1_reg <= res;
            end
            if (en2) begin
                v2_reg <= v1_reg;
                s2_reg <= part;
            end
            if (en3) begin
                v3_reg <= v2_reg;
                s3_reg <= ext;
            end
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // input side only backs up when every stage holds an item and the sink stalls
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !run_bytes.ready |-> (v1_reg && v2_reg && v3_reg && !extents.ready))
        else $error("input stalled with room in the pipeline");

    // offset phase is only entered with offset bytes still to come
    a_offset_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg.phase == PH_OFFSET) |-> (run_reg.off_left != '0))
        else $error("offset phase with no offset bytes left");

    // a sparse or bad result never carries a byte offset
    a_sparse_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (extents.valid && (extents.sparse_run || extents.bad_header))
            |-> (extents.extent_byte_offset == '0))
        else $error("nonzero offset on sparse or bad item");

    // a finished list accepts bytes without producing items until list_start
    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && fin_reg && !run_bytes.list_start) |=> !v1_reg)
        else $error("item produced after end of list");

endmodule

`default_nettype wire
